[rtl/core/c3rgb_pkg.sv]
// types and constants shared by the 3x3 rgb convolution block
`default_nettype none
package c3rgb_pkg;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL       = 2'd2;

    localparam int WIN_TAPS = 9;
    localparam int QDEPTH   = 2;

    typedef logic [23:0] pix_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic                    conv;
        logic                    frame_end;
        pix_t                    pix;
        pix_t [WIN_TAPS-1:0]     win;
    } job_t;

endpackage
`default_nettype wire

[rtl/core/c3rgb_ram.sv]
// generic single write, single registered read ram
`default_nettype none
module c3rgb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/c3rgb_front.sv]
// front end: accepts words, keeps row stores and window, classifies outputs
`default_nettype none
module c3rgb_front import c3rgb_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int WW = $clog2(MAX_WIDTH + 2)
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic [WW-1:0] eff_w,
    input  wire logic [15:0]   eff_h,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output job_t          job,
    output logic          push,
    input  wire logic     full
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    typedef enum logic {F_IDLE, F_PROC} fstate_t;

    fstate_t              state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [15:0]          row_reg, row_next;
    logic [WW-1:0]        pend_reg, pend_next;
    pix_t [WIN_TAPS-1:0]  win_reg, win_next;

    logic             rd_en, up_we, mid_we;
    logic [COL_W-1:0] rd_addr, drain_addr;
    pix_t             up_rd, mid_rd, up_pix, mid_pix, in_pix;
    logic [WW-1:0]    wp1, k, km1, col_ext;
    logic             col_last, row_last, border, emit;

    assign wp1        = eff_w + WW'(1);
    assign k          = (wp1 >= pend_reg) ? (wp1 - pend_reg) : '0;
    assign km1        = k - WW'(1);
    assign drain_addr = (km1 == WW'(MAX_WIDTH)) ? '0 : km1[COL_W-1:0];
    assign col_ext    = WW'(col_reg);
    assign col_last   = (col_ext + WW'(1)) >= eff_w;
    assign row_last   = (17'(row_reg) + 17'd1) >= 17'(eff_h);
    assign border     = (row_reg == 16'd1) || (row_reg >= eff_h) ||
                        (col_reg == COL_W'(1)) || ((col_ext + WW'(1)) > eff_w);
    assign emit       = (row_reg >= 16'd2) || ((row_reg == 16'd1) && (col_reg != '0));
    assign up_pix     = (row_reg >= 16'd2) ? up_rd : '0;
    assign mid_pix    = (row_reg != 16'd0) ? mid_rd : '0;
    assign in_pix     = {item_reg.in_red, item_reg.in_green, item_reg.in_blue};
    assign s_ready    = (state_reg == F_IDLE);
    assign rd_en      = s_valid && s_ready;
    assign rd_addr    = (s_data.req_type == REQ_DRAIN) ? drain_addr : col_reg;

    c3rgb_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk(aclk), .we(up_we), .waddr(col_reg), .wdata(mid_rd),
        .re(rd_en), .raddr(rd_addr), .rdata(up_rd)
    );

    c3rgb_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
        .aclk(aclk), .we(mid_we), .waddr(col_reg), .wdata(in_pix),
        .re(rd_en), .raddr(rd_addr), .rdata(mid_rd)
    );

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        win_next   = win_reg;
        push       = 1'b0;
        job        = '0;
        up_we      = 1'b0;
        mid_we     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = F_PROC;
                end
            end
            F_PROC: begin
                if (!full) begin
                    state_next = F_IDLE;
                    if (item_reg.req_type == REQ_DRAIN) begin
                        if (pend_reg != '0) begin
                            push          = 1'b1;
                            job.pix       = (k == '0) ? win_reg[5] : mid_rd;
                            job.frame_end = (pend_reg == WW'(1));
                            pend_next     = pend_reg - WW'(1);
                        end
                    end else begin
                        pend_next = '0;
                        up_we     = 1'b1;
                        mid_we    = 1'b1;
                        for (int a = 0; a < 3; a++) begin
                            win_next[a*3]   = win_reg[a*3+1];
                            win_next[a*3+1] = win_reg[a*3+2];
                        end
                        win_next[2] = up_pix;
                        win_next[5] = mid_pix;
                        win_next[8] = in_pix;
                        push     = emit;
                        job.conv = (col_reg != '0) && !border;
                        job.pix  = win_reg[5];
                        job.win  = win_next;
                        if (col_last) begin
                            col_next = '0;
                            if (row_last) begin
                                row_next  = '0;
                                pend_next = wp1;
                            end else begin
                                row_next = row_reg + 16'd1;
                            end
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            win_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            win_reg   <= win_next;
        end
        item_reg <= item_next;
    end

endmodule
`default_nettype wire

[rtl/core/c3rgb_fifo.sv]
// short job queue between front and back
`default_nettype none
module c3rgb_fifo import c3rgb_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t wr_job,
    output logic      full,
    input  wire logic pop,
    output job_t      rd_job,
    output logic      empty
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    job_t          mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full   = (cnt_reg == CW'(QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

[rtl/core/c3rgb_back.sv]
// back end: multiply-accumulate over the window, serial divide, clamp, output register
`default_nettype none
module c3rgb_back import c3rgb_pkg::*; #(
    parameter int COEFF_BITS = 5,
    localparam int KW = COEFF_BITS + 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire job_t                     job,
    input  wire logic                     empty,
    output logic                          pop,
    input  wire logic [9*COEFF_BITS-1:0]  kernel,
    input  wire logic signed [KW-1:0]     ksum,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_data
);

    localparam int AW = COEFF_BITS + 12;
    localparam int SW = $clog2(AW);
    localparam int PRW = COEFF_BITS + 9;

    typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_OUT} bstate_t;

    bstate_t                       state_reg;
    job_t                          job_reg;
    logic [3:0]                    tap_reg;
    logic [SW-1:0]                 step_reg;
    logic signed [2:0][AW-1:0]     acc_reg;
    logic [2:0][AW-1:0]            quo_reg;
    logic [2:0][KW-1:0]            rem_reg;
    logic [2:0]                    neg_reg;
    logic                          m_valid_reg;
    out_item_t                     m_data_reg;

    logic [KW-1:0]                 dv;
    logic signed [COEFF_BITS-1:0]  cf;
    logic signed [2:0][PRW-1:0]    prod;
    logic [2:0][KW:0]              shf;
    logic [2:0]                    ge;
    pix_t                          res;

    assign dv      = (ksum == '0) ? KW'(1) : (ksum[KW-1] ? KW'(-ksum) : KW'(ksum));
    assign cf      = $signed(kernel[tap_reg*COEFF_BITS +: COEFF_BITS]);
    assign pop     = (state_reg == B_IDLE) && !empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = cf * $signed({1'b0, job_reg.win[tap_reg][8*c +: 8]});
            shf[c]  = {rem_reg[c], quo_reg[c][AW-1]};
            ge[c]   = shf[c] >= {1'b0, dv};
            if (neg_reg[c]) begin
                res[8*c +: 8] = 8'd0;
            end else if (quo_reg[c] > AW'(255)) begin
                res[8*c +: 8] = 8'hFF;
            end else begin
                res[8*c +: 8] = quo_reg[c][7:0];
            end
        end
        if (!job_reg.conv) begin
            res = job_reg.pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != B_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!empty) begin
                        job_reg <= job;
                        tap_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= job.conv ? B_MAC : B_OUT;
                    end
                end
                B_MAC: begin
                    for (int c = 0; c < 3; c++) begin
                        acc_reg[c] <= acc_reg[c] + AW'($signed(prod[c]));
                    end
                    tap_reg <= tap_reg + 4'd1;
                    if (tap_reg == 4'(WIN_TAPS - 1)) begin
                        state_reg <= B_PREP;
                    end
                end
                B_PREP: begin
                    for (int c = 0; c < 3; c++) begin
                        neg_reg[c] <= acc_reg[c][AW-1] ^ ksum[KW-1];
                        quo_reg[c] <= acc_reg[c][AW-1] ? AW'(-acc_reg[c]) : AW'(acc_reg[c]);
                        rem_reg[c] <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    for (int c = 0; c < 3; c++) begin
                        rem_reg[c] <= ge[c] ? KW'(shf[c] - {1'b0, dv}) : shf[c][KW-1:0];
                        quo_reg[c] <= {quo_reg[c][AW-2:0], ge[c]};
                    end
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(AW - 1)) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{out_blue: res[7:0], out_green: res[15:8],
                                         out_red: res[23:16], frame_end: job_reg.frame_end};
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/conv3x3_rgb_normalized.sv]
// Streaming 3x3 RGB convolution normalized by the kernel sum. Each input word (pixel or
// drain) gets a registered row-store read, then the row-store and window update, which
// waits while the queue is full; no new word is taken until then. Pass-through outputs
// go from idle straight to the back end's output state; convolved ones first go through
// the one-tap-per-cycle multiply-accumulate, a prepare step and the one-bit-per-cycle
// divider. A 2-entry queue decouples the two halves. Row stores are not cleared
// after reset. Registers sit at byte addresses 0 (frame_width), 8 (frame_height) and 16
// (kernel_coeffs); write them only while the block is idle, which it does not enforce.
`default_nettype none
module conv3x3_rgb_normalized import c3rgb_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int COEFF_BITS = 5,
    localparam int KBW = 9 * COEFF_BITS,
    localparam int PDW = (KBW > 64) ? 128 : 64
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire in_item_t        s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output out_item_t            m_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [PDW-1:0]  pwdata,
    output logic      [PDW-1:0]  prdata,
    output logic                 pready
);

    localparam int WW = $clog2(MAX_WIDTH + 2);
    localparam int KW = COEFF_BITS + 4;
    localparam int CW = 14;

    logic [11:0]             fw_reg;
    logic [15:0]             fh_reg;
    logic [KBW-1:0]          kern_reg;
    logic signed [KW-1:0]    ksum_reg, ksum_next;
    logic [CW-1:0]           fw_ext, ew;
    logic [WW-1:0]           eff_w;
    logic [15:0]             eff_h;
    logic                    push, pop, full, empty;
    job_t                    wr_job, rd_job;

    assign pready = 1'b1;
    assign fw_ext = CW'(fw_reg);
    assign ew     = (fw_ext < CW'(3)) ? CW'(3) :
                    (fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext;
    assign eff_w  = WW'(ew);
    assign eff_h  = (fh_reg < 16'd3) ? 16'd3 : fh_reg;

    always_comb begin
        ksum_next = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            ksum_next = ksum_next + KW'($signed(kern_reg[i*COEFF_BITS +: COEFF_BITS]));
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_FRAME_WIDTH:  prdata = PDW'(fw_reg);
            REG_FRAME_HEIGHT: prdata = PDW'(fh_reg);
            REG_KERNEL:       prdata = PDW'(kern_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg   <= 12'd640;
            fh_reg   <= 16'd480;
            kern_reg <= KBW'(45'd1134979744801);
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_FRAME_WIDTH:  fw_reg   <= pwdata[11:0];
                REG_FRAME_HEIGHT: fh_reg   <= pwdata[15:0];
                REG_KERNEL:       kern_reg <= pwdata[KBW-1:0];
                default: ;
            endcase
        end
        ksum_reg <= ksum_next;
    end

    c3rgb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .eff_w(eff_w), .eff_h(eff_h),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .job(wr_job), .push(push), .full(full)
    );

    c3rgb_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .wr_job(wr_job), .full(full),
        .pop(pop), .rd_job(rd_job), .empty(empty)
    );

    c3rgb_back #(.COEFF_BITS(COEFF_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .job(rd_job), .empty(empty), .pop(pop),
        .kernel(kern_reg), .ksum(ksum_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue read while empty");

    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("front accepted back to back");

endmodule
`default_nettype wire
